// File: design/udrb_pkg.sv
// shared types, command and status codes for the dual uart ring buffer
// also holds the nibble to upper-case hex ascii conversion
// no dependencies
`default_nettype none

package udrb_pkg;

  typedef logic [2:0] cmd_t;
  typedef logic [1:0] status_t;
  typedef logic [7:0] byte_t;

  localparam cmd_t CMD_LINE_RX  = 3'd0;
  localparam cmd_t CMD_HOST_RD  = 3'd1;
  localparam cmd_t CMD_HOST_WR  = 3'd2;
  localparam cmd_t CMD_HOST_HEX = 3'd3;
  localparam cmd_t CMD_TX_READY = 3'd4;

  localparam status_t ST_DONE       = 2'd0;
  localparam status_t ST_RX_EMPTY   = 2'd1;
  localparam status_t ST_TX_NO_ROOM = 2'd2;
  localparam status_t ST_RX_OVERRUN = 2'd3;

  localparam byte_t HEX_ALPHA_BASE = 8'h40;
  localparam byte_t HEX_DIGIT_BASE = 8'h30;
  localparam logic [3:0] HEX_NIB_MASK = 4'hF;
  localparam logic [3:0] HEX_NIB_MAX  = 4'd9;

  // nibble to ascii: 0-9 -> '0'-'9', 10-15 -> 'A'-'F'
  function automatic byte_t hex_digit(input logic [3:0] nib);
    logic [3:0] n;
    n = nib & HEX_NIB_MASK;
    if (n > HEX_NIB_MAX) begin
      hex_digit = {4'd0, n - HEX_NIB_MAX} | HEX_ALPHA_BASE;
    end else begin
      hex_digit = {4'd0, n} | HEX_DIGIT_BASE;
    end
  endfunction

endpackage

`default_nettype wire

// File: design/udrb_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module udrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [$clog2(DEPTH)-1:0]           waddr,
  input  wire logic [WIDTH-1:0]                   wdata,
  input  wire logic                               re,
  input  wire logic [$clog2(DEPTH)-1:0]           raddr,
  output logic      [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/uart_dual_ring_buffer_core.sv
// top level of the dual uart ring buffer: receive and transmit rings
// depends on udrb_pkg and udrb_ram
`default_nettype none

// usage
//   input channel (in_valid / in_stall): one command per transaction, in_cmd
//   selects line byte arrival, host read, host write, host hex write or
//   transmitter ready; in_data carries the byte where one is needed
//   result channel (out_valid / out_stall): exactly one result transaction
//   per command with status, the byte read by the host, the byte handed to
//   the transmitter and the two flags after the command
// result path
//   writes and empty/full answers: result registered the cycle after accept
//   host read and transmitter ready with data: the byte passes the ring
//   ram read register, then the output register
//   hex write: result registered the cycle after accept; the block then
//   stays busy in S_HEX2 to write the low digit through the single tx ram
//   write port. one command at a time: none is taken until back in idle
// reset
//   rst_n clears positions, flags and control; ram contents stay undefined
//   and are never returned before being written
// stall
//   a result waits in the output register while out_stall is high; no new
//   command is taken until that register is free or drains that cycle
module uart_dual_ring_buffer_core #(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_cmd,
  input  wire logic [7:0] in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_status,
  output logic [7:0]      out_read_byte,
  output logic [7:0]      out_tx_byte,
  output logic            out_tx_byte_valid,
  output logic            out_rx_pending,
  output logic            out_tx_request_enable
);

  localparam int RAW = $clog2(RX_DEPTH);
  localparam int TAW = $clog2(TX_DEPTH);
  localparam logic [RAW-1:0] RX_LAST = RAW'(RX_DEPTH - 1);
  localparam logic [TAW-1:0] TX_LAST = TAW'(TX_DEPTH - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_HEX2 = 2'd2;

  // control state
  logic [1:0]     state_r, state_nxt;
  logic [RAW-1:0] rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt;
  logic [TAW-1:0] tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt;
  logic           rx_pend_r, rx_pend_nxt;
  logic           tx_req_r, tx_req_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           rd_is_tx_r, rd_is_tx_nxt;

  // payload registers
  udrb_pkg::status_t out_status_r, out_status_nxt;
  udrb_pkg::byte_t   out_rbyte_r, out_rbyte_nxt;
  udrb_pkg::byte_t   out_tbyte_r, out_tbyte_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  udrb_pkg::byte_t   hex_lo_r, hex_lo_nxt;

  // ram ports
  logic            rx_we, rx_re, tx_we, tx_re;
  logic [RAW-1:0]  rx_waddr, rx_raddr;
  logic [TAW-1:0]  tx_waddr, tx_raddr;
  udrb_pkg::byte_t tx_wdata, rx_rdata, tx_rdata;

  logic           out_free, accept;
  logic [RAW-1:0] rx_wp_inc, rx_rp_inc;
  logic [TAW-1:0] tx_wp_inc, tx_wp_inc2, tx_rp_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // position advance with wrap at the ring depth
  assign rx_wp_inc  = (rx_wp_r == RX_LAST) ? '0 : rx_wp_r + 1'b1;
  assign rx_rp_inc  = (rx_rp_r == RX_LAST) ? '0 : rx_rp_r + 1'b1;
  assign tx_wp_inc  = (tx_wp_r == TX_LAST) ? '0 : tx_wp_r + 1'b1;
  assign tx_wp_inc2 = (tx_wp_inc == TX_LAST) ? '0 : tx_wp_inc + 1'b1;
  assign tx_rp_inc  = (tx_rp_r == TX_LAST) ? '0 : tx_rp_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    rx_wp_nxt      = rx_wp_r;
    rx_rp_nxt      = rx_rp_r;
    tx_wp_nxt      = tx_wp_r;
    tx_rp_nxt      = tx_rp_r;
    rx_pend_nxt    = rx_pend_r;
    tx_req_nxt     = tx_req_r;
    out_valid_nxt  = out_valid_r && out_stall;
    rd_is_tx_nxt   = rd_is_tx_r;
    out_status_nxt = out_status_r;
    out_rbyte_nxt  = out_rbyte_r;
    out_tbyte_nxt  = out_tbyte_r;
    out_tvalid_nxt = out_tvalid_r;
    hex_lo_nxt     = hex_lo_r;
    rx_we    = 1'b0;
    rx_waddr = rx_wp_inc;
    rx_re    = 1'b0;
    rx_raddr = rx_rp_inc;
    tx_we    = 1'b0;
    tx_waddr = tx_wp_inc;
    tx_wdata = in_data;
    tx_re    = 1'b0;
    tx_raddr = tx_rp_inc;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // default result: done, no bytes, shown next cycle
          out_status_nxt = udrb_pkg::ST_DONE;
          out_rbyte_nxt  = '0;
          out_tbyte_nxt  = '0;
          out_tvalid_nxt = 1'b0;
          out_valid_nxt  = 1'b1;
          case (in_cmd)
            udrb_pkg::CMD_LINE_RX: begin
              if (rx_wp_inc == rx_rp_r) begin
                out_status_nxt = udrb_pkg::ST_RX_OVERRUN;
              end else begin
                rx_we       = 1'b1;
                rx_wp_nxt   = rx_wp_inc;
                rx_pend_nxt = 1'b1;
              end
            end
            udrb_pkg::CMD_HOST_RD: begin
              if (rx_wp_r == rx_rp_r) begin
                out_status_nxt = udrb_pkg::ST_RX_EMPTY;
              end else begin
                // byte comes back from the ram next cycle
                rx_re         = 1'b1;
                rx_rp_nxt     = rx_rp_inc;
                rx_pend_nxt   = rx_pend_r && (rx_wp_r != rx_rp_inc);
                rd_is_tx_nxt  = 1'b0;
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
              end
            end
            udrb_pkg::CMD_HOST_WR: begin
              if (tx_wp_inc == tx_rp_r) begin
                out_status_nxt = udrb_pkg::ST_TX_NO_ROOM;
              end else begin
                tx_we      = 1'b1;
                tx_wp_nxt  = tx_wp_inc;
                tx_req_nxt = 1'b1;
              end
            end
            udrb_pkg::CMD_HOST_HEX: begin
              // needs two free slots or nothing is stored
              if ((tx_wp_inc == tx_rp_r) || (tx_wp_inc2 == tx_rp_r)) begin
                out_status_nxt = udrb_pkg::ST_TX_NO_ROOM;
              end else begin
                tx_we      = 1'b1;
                tx_wdata   = udrb_pkg::hex_digit(in_data[7:4]);
                tx_wp_nxt  = tx_wp_inc2;
                tx_req_nxt = 1'b1;
                hex_lo_nxt = udrb_pkg::hex_digit(in_data[3:0]);
                state_nxt  = S_HEX2;
              end
            end
            udrb_pkg::CMD_TX_READY: begin
              if (tx_wp_r != tx_rp_r) begin
                tx_re         = 1'b1;
                tx_rp_nxt     = tx_rp_inc;
                rd_is_tx_nxt  = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
              end else begin
                // drained: stop asking the transmitter
                tx_req_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        // output register is free here: it was free or draining at accept
        if (rd_is_tx_r) begin
          out_tbyte_nxt  = tx_rdata;
          out_tvalid_nxt = 1'b1;
        end else begin
          out_rbyte_nxt = rx_rdata;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_HEX2: begin
        // low digit into the slot the write position now points at
        tx_we     = 1'b1;
        tx_waddr  = tx_wp_r;
        tx_wdata  = hex_lo_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rx_wp_r     <= '0;
      rx_rp_r     <= '0;
      tx_wp_r     <= '0;
      tx_rp_r     <= '0;
      rx_pend_r   <= 1'b0;
      tx_req_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rd_is_tx_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rx_wp_r     <= rx_wp_nxt;
      rx_rp_r     <= rx_rp_nxt;
      tx_wp_r     <= tx_wp_nxt;
      tx_rp_r     <= tx_rp_nxt;
      rx_pend_r   <= rx_pend_nxt;
      tx_req_r    <= tx_req_nxt;
      out_valid_r <= out_valid_nxt;
      rd_is_tx_r  <= rd_is_tx_nxt;
    end
  end

  // payload, flags are captured with the result and held while stalled
  logic rx_pend_out_r, tx_req_out_r;

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_rbyte_r   <= out_rbyte_nxt;
    out_tbyte_r   <= out_tbyte_nxt;
    out_tvalid_r  <= out_tvalid_nxt;
    hex_lo_r      <= hex_lo_nxt;
    if (accept) begin
      rx_pend_out_r <= rx_pend_nxt;
      tx_req_out_r  <= tx_req_nxt;
    end
  end

  udrb_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (in_data),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  udrb_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_read_byte         = out_rbyte_r;
  assign out_tx_byte           = out_tbyte_r;
  assign out_tx_byte_valid     = out_tvalid_r;
  assign out_rx_pending        = rx_pend_out_r;
  assign out_tx_request_enable = tx_req_out_r;

endmodule

`default_nettype wire

// File: tb/sv/udrb_checker.sv
`timescale 1ns / 100ps
// transaction checker for the dual uart ring buffer: watches both channels,
// predicts each result from its own copy of the rings and compares in order
// depends on udrb_pkg for command and status codes

module udrb_checker #(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  udrb_pkg::cmd_t    in_cmd,
  input  udrb_pkg::byte_t   in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  udrb_pkg::status_t out_status,
  input  udrb_pkg::byte_t   out_read_byte,
  input  udrb_pkg::byte_t   out_tx_byte,
  input  logic              out_tx_byte_valid,
  input  logic              out_rx_pending,
  input  logic              out_tx_request_enable,
  output int                mismatch_count,
  output int                pending_count
);

  typedef struct packed {
    udrb_pkg::status_t status;
    udrb_pkg::byte_t   read_byte;
    udrb_pkg::byte_t   tx_byte;
    logic              tx_byte_valid;
    logic              rx_pending;
    logic              tx_request_enable;
  } ring_result_t;

  // mirror of the block state
  udrb_pkg::byte_t rx_ring [RX_DEPTH];
  udrb_pkg::byte_t tx_ring [TX_DEPTH];
  int    rx_wr, rx_rd, tx_wr, tx_rd;
  logic  rx_pend, tx_req;

  ring_result_t expected_q [$];
  int           mismatches = 0;
  int           result_idx = 0;

  function automatic udrb_pkg::byte_t ascii_hex(input logic [3:0] nib);
    if (nib > udrb_pkg::HEX_NIB_MAX) begin
      return (udrb_pkg::byte_t'(nib) - udrb_pkg::byte_t'(udrb_pkg::HEX_NIB_MAX))
             | udrb_pkg::HEX_ALPHA_BASE;
    end
    return udrb_pkg::byte_t'(nib) | udrb_pkg::HEX_DIGIT_BASE;
  endfunction

  function automatic int tx_fill();
    return (tx_wr + TX_DEPTH - tx_rd) % TX_DEPTH;
  endfunction

  function automatic void tx_put(input udrb_pkg::byte_t b);
    tx_wr = (tx_wr + 1) % TX_DEPTH;
    tx_ring[tx_wr] = b;
  endfunction

  // advances the mirrored state by one command and returns its result
  function automatic ring_result_t predict_result(input udrb_pkg::cmd_t cmd,
                                                  input udrb_pkg::byte_t data);
    ring_result_t r;
    int nxt;
    r = '0;
    r.status = udrb_pkg::ST_DONE;
    case (cmd)
      udrb_pkg::CMD_LINE_RX: begin
        nxt = (rx_wr + 1) % RX_DEPTH;
        if (nxt == rx_rd) begin
          r.status = udrb_pkg::ST_RX_OVERRUN;
        end else begin
          rx_ring[nxt] = data;
          rx_wr = nxt;
          rx_pend = 1'b1;
        end
      end
      udrb_pkg::CMD_HOST_RD: begin
        if (rx_wr == rx_rd) begin
          r.status = udrb_pkg::ST_RX_EMPTY;
        end else begin
          rx_rd = (rx_rd + 1) % RX_DEPTH;
          r.read_byte = rx_ring[rx_rd];
          if (rx_wr == rx_rd) rx_pend = 1'b0;
        end
      end
      udrb_pkg::CMD_HOST_WR: begin
        if (tx_fill() + 1 > TX_DEPTH - 1) begin
          r.status = udrb_pkg::ST_TX_NO_ROOM;
        end else begin
          tx_put(data);
          tx_req = 1'b1;
        end
      end
      udrb_pkg::CMD_HOST_HEX: begin
        if (tx_fill() + 2 > TX_DEPTH - 1) begin
          r.status = udrb_pkg::ST_TX_NO_ROOM;
        end else begin
          tx_put(ascii_hex(data[7:4]));
          tx_put(ascii_hex(data[3:0]));
          tx_req = 1'b1;
        end
      end
      udrb_pkg::CMD_TX_READY: begin
        if (tx_wr != tx_rd) begin
          tx_rd = (tx_rd + 1) % TX_DEPTH;
          r.tx_byte = tx_ring[tx_rd];
          r.tx_byte_valid = 1'b1;
        end else begin
          tx_req = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.rx_pending = rx_pend;
    r.tx_request_enable = tx_req;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    ring_result_t want;
    ring_result_t got;
    if (!rst_n) begin
      rx_wr = 0;
      rx_rd = 0;
      tx_wr = 0;
      tx_rd = 0;
      rx_pend = 1'b0;
      tx_req = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.read_byte = out_read_byte;
        got.tx_byte = out_tx_byte;
        got.tx_byte_valid = out_tx_byte_valid;
        got.rx_pending = out_rx_pending;
        got.tx_request_enable = out_tx_request_enable;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: no result expected, got status=%0d rd=%02h tx=%02h/%0b",
                     result_idx, got.status, got.read_byte, got.tx_byte, got.tx_byte_valid);
          end
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: expected status=%0d rd=%02h tx=%02h/%0b pend=%0b req=%0b",
                       result_idx, want.status, want.read_byte, want.tx_byte,
                       want.tx_byte_valid, want.rx_pending, want.tx_request_enable);
              $display("result %0d:      got status=%0d rd=%02h tx=%02h/%0b pend=%0b req=%0b",
                       result_idx, got.status, got.read_byte, got.tx_byte,
                       got.tx_byte_valid, got.rx_pending, got.tx_request_enable);
            end
          end
        end
        result_idx++;
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(predict_result(in_cmd, in_data));
      end
    end
    mismatch_count <= mismatches;
    pending_count <= expected_q.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// top of the dual uart ring buffer testbench: clock, reset, command stimulus,
// receiver stall pattern, watchdog and verdict
// depends on udrb_pkg, uart_dual_ring_buffer_core and udrb_checker

module testbench;

  localparam int RX_DEPTH       = 256;
  localparam int TX_DEPTH       = 256;
  localparam int HOLD_AFTER     = 500;   // transactions sent before the long receiver hold
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;  // idle cycles, well above the hold plus a gap
  localparam int DRAIN_CYCLES   = 16;

  // shapes of random traffic: the first four each drive one ring toward full or empty, PH_MIX mixes all five commands
  typedef enum int {PH_RX_FILL, PH_TX_FILL, PH_RX_DRAIN, PH_TX_DRAIN, PH_MIX} load_phase_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  udrb_pkg::cmd_t    in_cmd;
  udrb_pkg::byte_t   in_data;
  logic              out_valid;
  logic              out_stall;
  udrb_pkg::status_t out_status;
  udrb_pkg::byte_t   out_read_byte;
  udrb_pkg::byte_t   out_tx_byte;
  logic              out_tx_byte_valid;
  logic              out_rx_pending;
  logic              out_tx_request_enable;

  int mismatch_count;
  int pending_count;

  // sender bookkeeping
  int sent_count  = 0;
  int burst_left  = 0;
  bit hold_active = 1'b0;
  bit hold_done   = 1'b0;
  int idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  uart_dual_ring_buffer_core #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_data              (in_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_read_byte        (out_read_byte),
    .out_tx_byte          (out_tx_byte),
    .out_tx_byte_valid    (out_tx_byte_valid),
    .out_rx_pending       (out_rx_pending),
    .out_tx_request_enable(out_tx_request_enable)
  );

  udrb_checker #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_data              (in_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_read_byte        (out_read_byte),
    .out_tx_byte          (out_tx_byte),
    .out_tx_byte_valid    (out_tx_byte_valid),
    .out_rx_pending       (out_rx_pending),
    .out_tx_request_enable(out_tx_request_enable),
    .mismatch_count       (mismatch_count),
    .pending_count        (pending_count)
  );

  // offer one command and hold it until the block takes it; bursts of random
  // length with random gaps, no gaps while the receiver is held off
  task automatic offer(input udrb_pkg::cmd_t c, input udrb_pkg::byte_t d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (hold_active) gap = 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd   <= c;
    in_data  <= d;
    // stall is sampled as it stood before the edge
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // command mix per phase, with a little noise over all eight codes
  function automatic udrb_pkg::cmd_t pick_cmd(input load_phase_t ph);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return udrb_pkg::cmd_t'($urandom_range(0, 7));
    case (ph)
      PH_RX_FILL:  return (roll < 95) ? udrb_pkg::CMD_LINE_RX : udrb_pkg::CMD_HOST_RD;
      PH_RX_DRAIN: return (roll < 95) ? udrb_pkg::CMD_HOST_RD : udrb_pkg::CMD_LINE_RX;
      PH_TX_FILL:  return (roll < 50) ? udrb_pkg::CMD_HOST_WR :
                          (roll < 95) ? udrb_pkg::CMD_HOST_HEX : udrb_pkg::CMD_TX_READY;
      PH_TX_DRAIN: return (roll < 94) ? udrb_pkg::CMD_TX_READY :
                          (roll < 97) ? udrb_pkg::CMD_HOST_WR : udrb_pkg::CMD_HOST_HEX;
      default:     return udrb_pkg::cmd_t'($urandom_range(0, 4));
    endcase
  endfunction

  // main stimulus and verdict
  initial begin
    load_phase_t plan_phase [5];
    int          plan_len [5];
    int          p, n;
    plan_phase = '{PH_RX_FILL, PH_TX_FILL, PH_RX_DRAIN, PH_TX_DRAIN, PH_MIX};
    plan_len   = '{340, 240, 320, 330, 170};

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_cmd   <= udrb_pkg::CMD_LINE_RX;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: empty answers right after reset
    offer(udrb_pkg::CMD_HOST_RD, 8'h00);
    offer(udrb_pkg::CMD_TX_READY, 8'h00);
    // unused codes change nothing
    offer(udrb_pkg::cmd_t'(5), 8'hFF);
    offer(udrb_pkg::cmd_t'(6), 8'h00);
    offer(udrb_pkg::cmd_t'(7), 8'hA5);
    // line bytes at both extremes, read back, second read clears pending, third answers empty
    offer(udrb_pkg::CMD_LINE_RX, 8'h00);
    offer(udrb_pkg::CMD_LINE_RX, 8'hFF);
    offer(udrb_pkg::CMD_HOST_RD, 8'h00);
    offer(udrb_pkg::CMD_HOST_RD, 8'h00);
    offer(udrb_pkg::CMD_HOST_RD, 8'h00);
    // plain and hex writes, digits and letters on both nibbles
    offer(udrb_pkg::CMD_HOST_WR, 8'h00);
    offer(udrb_pkg::CMD_HOST_WR, 8'hFF);
    offer(udrb_pkg::CMD_HOST_HEX, 8'h00);
    offer(udrb_pkg::CMD_HOST_HEX, 8'h9A);
    offer(udrb_pkg::CMD_HOST_HEX, 8'hFF);
    offer(udrb_pkg::CMD_HOST_HEX, 8'hA9);
    // drain all ten bytes, then one more on empty clears the request enable
    repeat (11) offer(udrb_pkg::CMD_TX_READY, 8'h00);

    // random phases: fills reach overrun and no-room, drains reach empty
    for (p = 0; p < 5; p++) begin
      for (n = 0; n < plan_len[p]; n++) begin
        offer(pick_cmd(plan_phase[p]), udrb_pkg::byte_t'($urandom_range(0, 255)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // receiver: segments of random length, each with its own stall mode, and
  // one long hold once enough traffic has gone through so the block backs up
  initial begin
    int seg, mode, k;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(16, 96);
      for (k = 0; k < seg; k++) begin
        @(posedge clk);
        if (!hold_done && sent_count >= HOLD_AFTER) begin
          hold_active = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_active = 1'b0;
          hold_done   = 1'b1;
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (k % 3 == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// File: files.f
design/udrb_pkg.sv
design/udrb_ram.sv
design/uart_dual_ring_buffer_core.sv
tb/sv/udrb_checker.sv
tb/sv/testbench.sv
